[rtl/core/mms_pkg.sv]
package mms_pkg;

  localparam int STAT_WORDS = 20;
  localparam int CFG_WIDTH = 17;
  localparam logic [10:0] DAY_SELECT = 11'd1024;
  localparam logic [16:0] DAY_SECONDS = 17'd86400;
  localparam logic [16:0] MINUTE_SECONDS = 17'd60;
  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] MODE_QUOTE = 2'd0;
  localparam logic [1:0] MODE_TRADE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] SIDE_BUY = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  localparam logic CFG_WINDOW_START = 1'b0;
  localparam logic CFG_WINDOW_END = 1'b1;

  localparam logic [4:0] W_STAMP = 5'd0;
  localparam logic [4:0] W_QCOUNT = 5'd1;
  localparam logic [4:0] W_MID_SUM = 5'd2;
  localparam logic [4:0] W_MID_SQ = 5'd3;
  localparam logic [4:0] W_MID_MIN = 5'd4;
  localparam logic [4:0] W_MID_MAX = 5'd5;
  localparam logic [4:0] W_SPR_SUM = 5'd6;
  localparam logic [4:0] W_SPR_MIN = 5'd7;
  localparam logic [4:0] W_SPR_MAX = 5'd8;
  localparam logic [4:0] W_L1_SIZE = 5'd9;
  localparam logic [4:0] W_TCOUNT = 5'd10;
  localparam logic [4:0] W_PX_SUM = 5'd11;
  localparam logic [4:0] W_SZ_SUM = 5'd12;
  localparam logic [4:0] W_SZ_MIN = 5'd13;
  localparam logic [4:0] W_SZ_MAX = 5'd14;
  localparam logic [4:0] W_BUY_VOL = 5'd15;
  localparam logic [4:0] W_SELL_VOL = 5'd16;
  localparam logic [4:0] W_VOLUME = 5'd17;
  localparam logic [4:0] W_PXSZ_SUM = 5'd18;
  localparam logic [4:0] W_PPSZ_SUM = 5'd19;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] time_sec;
    logic [23:0] bid_price;
    logic [23:0] ask_price;
    logic [23:0] bid_size;
    logic [23:0] ask_size;
    logic [23:0] trade_price;
    logic [23:0] trade_size;
    logic [1:0]  trade_side;
    logic [10:0] bin_select;
  } item_t;

  typedef struct packed {
    logic [4:0]         stat_id;
    logic signed [63:0] stat_value;
    logic               bin_empty;
    logic               last;
  } result_t;

  function automatic logic signed [63:0] reset_word(input logic [4:0] k);
    logic signed [63:0] v;
    v = '0;
    if (k == W_MID_MIN || k == W_SPR_MIN || k == W_SZ_MIN) v = SUM_MAX;
    return v;
  endfunction

endpackage

[rtl/core/mms_div.sv]
module mms_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic        by_day,
  output logic [31:0] rem,
  output logic [31:0] quo,
  output logic        done
);
  import mms_pkg::*;

  // floor(2^48 / 86400) and floor(2^37 / 60); the quotient estimate is short
  // by at most one for any 32-bit dividend
  localparam logic [31:0] RECIP_DAY = 32'd3257812230;
  localparam logic [31:0] RECIP_MIN = 32'd2290649224;

  typedef enum logic [2:0] {
    D_IDLE, D_MUL, D_EST, D_REM, D_FIX
  } dstate_t;

  dstate_t     dstate;
  logic        day;
  logic [31:0] n;
  logic [63:0] prod;
  logic [31:0] qe;
  logic [31:0] mconst;
  logic [31:0] dconst;
  logic [31:0] back;

  assign mconst = day ? RECIP_DAY : RECIP_MIN;
  assign dconst = day ? 32'(DAY_SECONDS) : 32'(MINUTE_SECONDS);
  assign back = day ? qe * 32'(DAY_SECONDS) : qe * 32'(MINUTE_SECONDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (go) begin
            n <= dividend;
            day <= by_day;
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          prod <= 64'(n) * 64'(mconst);
          dstate <= D_EST;
        end
        D_EST: begin
          qe <= day ? 32'(prod[63:48]) : 32'(prod[63:37]);
          dstate <= D_REM;
        end
        D_REM: begin
          rem <= n - back;
          quo <= qe;
          dstate <= D_FIX;
        end
        D_FIX: begin
          // advance a short estimate by one
          if (rem >= dconst) begin
            rem <= rem - dconst;
            quo <= quo + 32'd1;
          end
          done <= 1'b1;
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mms_mul.sv]
module mms_mul (
  input  logic        clk,
  input  logic [24:0] a,
  input  logic [24:0] b,
  output logic [49:0] p
);
  import mms_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[rtl/core/mms_store.sv]
module mms_store #(
  parameter int DEPTH = 20500,
  parameter int AW = 15
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [63:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [63:0]   rdata
);
  import mms_pkg::*;

  logic signed [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/minute_bar_market_stats.sv]
// Update item: setup (three reciprocal divisions, five passes through the
// shared multiplier), then an update of the day totals and of the minute bin
// when it is in the store; a gated-off item ends after its first division.
// Read item: 20 result words, with a gap between strobes. Results come on
// strobe and cannot be stalled. Synchronous reset, then a clearing pass of
// all (NUM_BINS + 1) * 20 words before the first item is taken.
module minute_bar_market_stats #(
  parameter int NUM_BINS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  mms_pkg::item_t           item,
  output logic                     strobe,
  output mms_pkg::result_t         result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [16:0]              cfg_data
);
  import mms_pkg::*;

  localparam int DEPTH = (NUM_BINS + 1) * STAT_WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(NUM_BINS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SOD, S_MIN, S_BIN, S_MUL, S_PPS,
    S_URD, S_UWR, S_ERD, S_EMPTY, S_RRD, S_ROUT
  } state_t;

  state_t state;
  item_t  it;
  logic [16:0] wstart, wend;
  logic [16:0] sod;
  logic [10:0] bin;
  logic [RW-1:0] row;
  logic [4:0] k;
  logic [2:0] mstep;
  logic [AW-1:0] caddr;
  logic missing, empty;
  logic signed [63:0] stamp, ppsz;
  logic [49:0] m2sq;
  logic [47:0] pxsz, p3, p4;
  logic [23:0] ph;

  logic go;
  logic [31:0] dvd;
  logic dday;
  logic [31:0] drem, dquo;
  logic ddone;

  logic [24:0] ma, mb;
  logic [49:0] mul_p;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [63:0] wdata, rdata, nv;

  logic [24:0] m2;
  logic signed [24:0] spread;
  logic [23:0] szhalf;
  logic [24:0] szsum;
  logic bin_in_store;
  logic [71:0] ptot;

  mms_div u_div (
    .clk(clk), .rst(rst), .go(go), .dividend(dvd), .by_day(dday),
    .rem(drem), .quo(dquo), .done(ddone)
  );

  mms_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mul_p));

  mms_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign m2 = 25'(it.bid_price) + 25'(it.ask_price);
  assign spread = $signed({1'b0, it.ask_price}) - $signed({1'b0, it.bid_price});
  assign szsum = 25'(it.bid_size) + 25'(it.ask_size);
  assign szhalf = szsum[24:1];
  assign bin_in_store = 32'(bin) < 32'(NUM_BINS);
  assign ptot = {p4, 24'd0} + 72'(p3);

  assign raddr = AW'(AW'(row) * AW'(STAT_WORDS) + AW'(k));
  assign we = (state == S_CLEAR) || (state == S_UWR);
  assign waddr = (state == S_CLEAR) ? caddr : raddr;
  assign wdata = (state == S_CLEAR) ? reset_word(k) : nv;
  assign busy = (state != S_IDLE);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SUM_MIN : SUM_MAX;
    return s[63:0];
  endfunction

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (mstep)
      3'd0: begin ma = m2; mb = m2; end
      3'd1: begin ma = 25'(it.trade_price); mb = 25'(it.trade_size); end
      3'd2: begin ma = 25'(it.trade_price); mb = 25'(it.trade_price); end
      3'd3: begin ma = 25'(mul_p[23:0]); mb = 25'(it.trade_size); end
      3'd4: begin ma = 25'(ph); mb = 25'(it.trade_size); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // new value of statistic word k
  always_comb begin
    logic signed [63:0] sz64, px64, m264, spr64;
    sz64 = 64'(it.trade_size);
    px64 = 64'(it.trade_price);
    m264 = 64'(m2);
    spr64 = 64'(spread);
    nv = rdata;
    if (k == W_STAMP) begin
      nv = stamp;
    end else if (it.mode == MODE_QUOTE) begin
      case (k)
        W_QCOUNT:  nv = sat_add(rdata, 64'sd1);
        W_MID_SUM: nv = sat_add(rdata, m264);
        W_MID_SQ:  nv = sat_add(rdata, 64'(m2sq));
        W_MID_MIN: nv = (m264 < rdata) ? m264 : rdata;
        W_MID_MAX: nv = (m264 > rdata) ? m264 : rdata;
        W_SPR_SUM: nv = sat_add(rdata, spr64);
        W_SPR_MIN: nv = (spr64 < rdata) ? spr64 : rdata;
        W_SPR_MAX: nv = (spr64 > rdata) ? spr64 : rdata;
        W_L1_SIZE: nv = sat_add(rdata, 64'(szhalf));
        default:   nv = rdata;
      endcase
    end else begin
      case (k)
        W_TCOUNT:   nv = sat_add(rdata, 64'sd1);
        W_PX_SUM:   nv = sat_add(rdata, px64);
        W_SZ_SUM:   nv = sat_add(rdata, sz64);
        W_SZ_MIN:   nv = (sz64 < rdata) ? sz64 : rdata;
        W_SZ_MAX:   nv = (sz64 > rdata) ? sz64 : rdata;
        W_BUY_VOL:  nv = (it.trade_side == SIDE_BUY) ? sat_add(rdata, sz64) : rdata;
        W_SELL_VOL: nv = (it.trade_side == SIDE_SELL) ? sat_add(rdata, sz64) : rdata;
        W_VOLUME:   nv = sat_add(rdata, sz64);
        W_PXSZ_SUM: nv = sat_add(rdata, 64'(pxsz));
        W_PPSZ_SUM: nv = sat_add(rdata, ppsz);
        default:    nv = rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      caddr <= '0;
      k <= '0;
      go <= 1'b0;
      strobe <= 1'b0;
      mstep <= '0;
      wstart <= 17'd0;
      wend <= 17'd36000;
    end else begin
      go <= 1'b0;
      strobe <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW_START) wstart <= cfg_data;
        else wend <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          k <= (k == 5'(STAT_WORDS - 1)) ? 5'd0 : k + 5'd1;
          caddr <= caddr + AW'(1);
          if (caddr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            it <= item;
            if (item.mode == MODE_QUOTE || item.mode == MODE_TRADE) begin
              go <= 1'b1;
              dvd <= item.time_sec;
              dday <= 1'b1;
              state <= S_SOD;
            end else if (item.mode == MODE_READ) begin
              missing <= 1'b0;
              row <= RW'(item.bin_select);
              if (item.bin_select == DAY_SELECT) row <= RW'(NUM_BINS);
              else if (32'(item.bin_select) >= 32'(NUM_BINS)) missing <= 1'b1;
              k <= W_QCOUNT;
              state <= S_ERD;
            end
          end
        end
        S_SOD: begin
          if (ddone) begin
            sod <= drem[16:0];
            if (drem[16:0] > wstart && drem[16:0] < wend &&
                it.bid_size != 24'd0 && it.ask_size != 24'd0) begin
              go <= 1'b1;
              dday <= 1'b0;
              state <= S_MIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MIN: begin
          if (ddone) begin
            stamp <= 64'(it.time_sec - drem);
            go <= 1'b1;
            dvd <= 32'(sod - wstart);
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (ddone) begin
            bin <= dquo[10:0];
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: m2sq <= mul_p;
            3'd2: pxsz <= mul_p[47:0];
            3'd3: ph <= mul_p[47:24];
            3'd4: p3 <= mul_p[47:0];
            3'd5: begin
              p4 <= mul_p[47:0];
              state <= S_PPS;
            end
            default: ;
          endcase
        end
        S_PPS: begin
          ppsz <= (ptot[71:63] != 9'd0) ? SUM_MAX : 64'(ptot[62:0]);
          row <= RW'(NUM_BINS);
          k <= '0;
          state <= S_URD;
        end
        S_URD: state <= S_UWR;
        S_UWR: begin
          if (k == 5'(STAT_WORDS - 1)) begin
            k <= '0;
            // day totals first, then the minute bin
            if (row == RW'(NUM_BINS) && bin_in_store) begin
              row <= RW'(bin);
              state <= S_URD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            k <= k + 5'd1;
            state <= S_URD;
          end
        end
        S_ERD: state <= S_EMPTY;
        S_EMPTY: begin
          empty <= missing || (rdata == 64'sd0);
          k <= '0;
          state <= S_RRD;
        end
        S_RRD: state <= S_ROUT;
        S_ROUT: begin
          strobe <= 1'b1;
          result.stat_id <= k;
          result.stat_value <= missing ? 64'sd0 : rdata;
          result.bin_empty <= empty;
          result.last <= (k == 5'(STAT_WORDS - 1));
          if (k == 5'(STAT_WORDS - 1)) begin
            state <= S_IDLE;
          end else begin
            k <= k + 5'd1;
            state <= S_RRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_ROUT)) else $error("result without read step");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe) else $error("word after last");
  a_word_spacing: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> !strobe ##1 strobe) else $error("readout gap");
  a_no_write_reading: assert property (@(posedge clk) disable iff (rst)
    (state == S_RRD || state == S_ROUT) |-> !we) else $error("write during readout");
`endif

endmodule
